// ===== src/knn_pkg.sv =====
package knn_pkg;

    // Default sizes for the top level parameters
    localparam int K_DEFAULT          = 16;
    localparam int COORD_BITS_DEFAULT = 24;

    // Fixed field widths
    localparam int QUERY_BITS     = 24;
    localparam int BOX_BITS       = 24;
    localparam int ID_BITS        = 32;
    localparam int DIST_BITS      = 52;
    localparam int INDEX_BITS     = 6;
    localparam int FUNC_BITS      = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // Queue depths (log2)
    localparam int CMDQ_DEPTH_LOG2 = 1;
    localparam int RESQ_DEPTH_LOG2 = 1;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic [BOX_BITS-1:0]  BOX_RESET = '1;

    // Item function codes
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_OFFER = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_QUERY_X     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_QUERY_Y     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_QUERY_Z     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_QUERY_ID    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_SIZE    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIODIC_ON = 3'd5;

    // Classified item handed from the front to the list unit
    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic                 self_hit;
        logic [ID_BITS-1:0]   id;
        logic [DIST_BITS-1:0] sq_dist;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic                  inserted;
        logic [DIST_BITS-1:0]  worst_dist;
        logic [INDEX_BITS-1:0] entry_index;
        logic [ID_BITS-1:0]    entry_id;
        logic [DIST_BITS-1:0]  entry_dist;
        logic                  entry_valid;
        logic                  last;
    } result_t;

endpackage

// ===== src/knn_fifo.sv =====
module knn_fifo import knn_pkg::*; #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg;
    logic [DEPTH_LOG2-1:0] rd_ptr_reg;
    logic [DEPTH_LOG2:0]   count_reg;

    assign full    = (count_reg == (DEPTH_LOG2+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/knn_front.sv =====
module knn_front import knn_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // item side
    input  logic                        push,
    output logic                        full,
    input  logic [FUNC_BITS-1:0]        func,
    input  logic signed [QUERY_BITS-1:0] cand_x,
    input  logic signed [QUERY_BITS-1:0] cand_y,
    input  logic signed [QUERY_BITS-1:0] cand_z,
    input  logic [ID_BITS-1:0]          cand_id,
    // configuration
    input  logic                        cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data,
    // to the command queue
    output logic                        cmd_push,
    output cmd_t                        cmd_data,
    input  logic                        cmd_full
);

    localparam int CW   = (COORD_BITS > QUERY_BITS) ? COORD_BITS : QUERY_BITS;
    localparam int DW   = CW + 1;
    localparam int MW   = DW;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = SQW + 2;

    // Configuration registers
    logic signed [QUERY_BITS-1:0] query_reg [3];
    logic [ID_BITS-1:0]           query_id_reg;
    logic [BOX_BITS-1:0]          box_reg;
    logic                         periodic_reg;

    // Pipeline control
    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Pipeline payload
    logic [FUNC_BITS-1:0] func1_reg, func2_reg, func3_reg, func4_reg;
    logic                 self1_reg, self2_reg, self3_reg, self4_reg;
    logic [ID_BITS-1:0]   id1_reg, id2_reg, id3_reg, id4_reg;
    logic signed [DW-1:0] diff_reg [3];
    logic [MW-1:0]        mag_reg  [3];
    logic [SQW-1:0]       sq_reg   [3];
    logic [DIST_BITS-1:0] dist_reg;

    logic [COORD_BITS:0]          raw   [3];
    logic signed [COORD_BITS-1:0] coord [3];
    logic [SUMW-1:0]              sum;

    // Minimum-image fold of one axis difference, then its magnitude
    function automatic logic [MW-1:0] fold_mag(input logic signed [DW-1:0] d,
                                               input logic [BOX_BITS-1:0] box,
                                               input logic per);
        logic signed [DW+1:0] d2;
        logic signed [DW+1:0] b2;
        logic signed [DW-1:0] f;
        logic signed [DW-1:0] bw;
        d2 = (DW+2)'(d) <<< 1;
        b2 = signed'((DW+2)'(box));
        bw = signed'(DW'(box));
        f  = d;
        if (per)
        begin
            if (d2 > b2)
            begin
                f = d - bw;
            end
            else if (d2 < -b2)
            begin
                f = d + bw;
            end
        end
        return f[DW-1] ? MW'(unsigned'(-f)) : MW'(unsigned'(f));
    endfunction

    // Candidate coordinates read as COORD_BITS-bit two's complement
    assign raw[0]   = {1'b0, cand_x};
    assign raw[1]   = {1'b0, cand_y};
    assign raw[2]   = {1'b0, cand_z};
    assign coord[0] = signed'(raw[0][COORD_BITS-1:0]);
    assign coord[1] = signed'(raw[1][COORD_BITS-1:0]);
    assign coord[2] = signed'(raw[2][COORD_BITS-1:0]);

    // The whole pipe holds when the last stage cannot hand over
    assign advance  = !(v4_reg && cmd_full);
    assign full     = !advance;
    assign cmd_push = v4_reg && !cmd_full;

    assign sum = SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);

    always_comb
    begin
        cmd_data.func     = func4_reg;
        cmd_data.self_hit = self4_reg;
        cmd_data.id       = id4_reg;
        cmd_data.sq_dist  = dist_reg;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_reg[0] <= '0;
            query_reg[1] <= '0;
            query_reg[2] <= '0;
            query_id_reg <= '0;
            box_reg      <= BOX_RESET;
            periodic_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_QUERY_X:     query_reg[0] <= signed'(cfg_data[QUERY_BITS-1:0]);
                CFG_QUERY_Y:     query_reg[1] <= signed'(cfg_data[QUERY_BITS-1:0]);
                CFG_QUERY_Z:     query_reg[2] <= signed'(cfg_data[QUERY_BITS-1:0]);
                CFG_QUERY_ID:    query_id_reg <= cfg_data[ID_BITS-1:0];
                CFG_BOX_SIZE:    box_reg      <= cfg_data[BOX_BITS-1:0];
                CFG_PERIODIC_ON: periodic_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Differences, fold, squares, sum with saturation
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            func1_reg <= func;
            self1_reg <= (cand_id == query_id_reg);
            id1_reg   <= cand_id;
            func2_reg <= func1_reg;
            self2_reg <= self1_reg;
            id2_reg   <= id1_reg;
            func3_reg <= func2_reg;
            self3_reg <= self2_reg;
            id3_reg   <= id2_reg;
            func4_reg <= func3_reg;
            self4_reg <= self3_reg;
            id4_reg   <= id3_reg;
            for (int a = 0; a < 3; a++)
            begin
                diff_reg[a] <= DW'(coord[a]) - DW'(query_reg[a]);
                mag_reg[a]  <= fold_mag(diff_reg[a], box_reg, periodic_reg);
                sq_reg[a]   <= SQW'(mag_reg[a]) * SQW'(mag_reg[a]);
            end
            dist_reg <= (sum > SUMW'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
        end
    end

endmodule

// ===== src/knn_list.sv =====
module knn_list import knn_pkg::*; #(
    parameter int K = K_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    // from the command queue
    input  cmd_t    cmd_rd,
    input  logic    cmd_empty,
    output logic    cmd_pop,
    // to the result queue
    output logic    res_push,
    output result_t res_data,
    input  logic    res_full
);

    localparam int CW = (K > 1) ? $clog2(K) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg, state_next;

    // Neighbor list, ascending by distance
    logic [DIST_BITS-1:0] dist_reg  [K];
    logic [DIST_BITS-1:0] dist_next [K];
    logic [ID_BITS-1:0]   id_reg    [K];
    logic [ID_BITS-1:0]   id_next   [K];
    logic [K-1:0]         valid_reg, valid_next;

    // Offer bookkeeping
    logic [K-1:0]         gt_reg;
    logic [K-1:0]         dup_reg;
    logic                 cur_self_reg;
    logic [ID_BITS-1:0]   cur_id_reg;
    logic [DIST_BITS-1:0] cur_dist_reg;

    // Read-out bookkeeping
    logic [CW-1:0]        cnt_reg;
    logic [DIST_BITS-1:0] worst_reg;

    logic [K-1:0] gt_row;
    logic [K-1:0] dup_row;
    logic         ins_ok;
    logic         read_last;
    logic         load_offer;
    logic         load_read;

    // Compare row against the queue head
    always_comb
    begin
        for (int i = 0; i < K; i++)
        begin
            gt_row[i]  = dist_reg[i] > cmd_rd.sq_dist;
            dup_row[i] = valid_reg[i] && (id_reg[i] == cmd_rd.id);
        end
    end

    assign ins_ok    = gt_reg[K-1] && !cur_self_reg && !(|dup_reg);
    assign read_last = (cnt_reg == CW'(K-1));

    // Sequencer and list update
    always_comb
    begin
        int p;
        int n;
        p          = 0;
        n          = 0;
        state_next = state_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        load_offer = 1'b0;
        load_read  = 1'b0;
        res_data   = '0;
        valid_next = valid_reg;
        for (int i = 0; i < K; i++)
        begin
            dist_next[i] = dist_reg[i];
            id_next[i]   = id_reg[i];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd_rd.func)
                        FUNC_OFFER:
                        begin
                            cmd_pop    = 1'b1;
                            load_offer = 1'b1;
                            state_next = S_INS;
                        end
                        FUNC_READ:
                        begin
                            cmd_pop    = 1'b1;
                            load_read  = 1'b1;
                            state_next = S_READ;
                        end
                        FUNC_CLEAR:
                        begin
                            if (!res_full)
                            begin
                                cmd_pop             = 1'b1;
                                res_push            = 1'b1;
                                res_data.worst_dist = DIST_MAX;
                                res_data.last       = 1'b1;
                                valid_next          = '0;
                                for (int i = 0; i < K; i++)
                                begin
                                    dist_next[i] = DIST_MAX;
                                    id_next[i]   = '0;
                                end
                            end
                        end
                        default:
                        begin
                            if (!res_full)
                            begin
                                cmd_pop             = 1'b1;
                                res_push            = 1'b1;
                                res_data.worst_dist = dist_reg[K-1];
                                res_data.last       = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_INS:
            begin
                if (!res_full)
                begin
                    // Shift the larger entries back and drop the old tail
                    if (ins_ok)
                    begin
                        for (int i = 0; i < K; i++)
                        begin
                            p = (i == 0) ? 0 : i - 1;
                            if (gt_reg[i])
                            begin
                                if (i > 0 && gt_reg[p])
                                begin
                                    dist_next[i]  = dist_reg[p];
                                    id_next[i]    = id_reg[p];
                                    valid_next[i] = valid_reg[p];
                                end
                                else
                                begin
                                    dist_next[i]  = cur_dist_reg;
                                    id_next[i]    = cur_id_reg;
                                    valid_next[i] = 1'b1;
                                end
                            end
                        end
                    end
                    res_push            = 1'b1;
                    res_data.inserted   = ins_ok;
                    res_data.worst_dist = dist_next[K-1];
                    res_data.last       = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            S_READ:
            begin
                if (!res_full)
                begin
                    res_push             = 1'b1;
                    res_data.worst_dist  = worst_reg;
                    res_data.entry_index = INDEX_BITS'(cnt_reg);
                    res_data.entry_id    = id_reg[0];
                    res_data.entry_dist  = dist_reg[0];
                    res_data.entry_valid = valid_reg[0];
                    res_data.last        = read_last;
                    // Rotate the list by one rank; K steps restore it
                    for (int i = 0; i < K; i++)
                    begin
                        n = (i == K - 1) ? 0 : i + 1;
                        dist_next[i]  = dist_reg[n];
                        id_next[i]    = id_reg[n];
                        valid_next[i] = valid_reg[n];
                    end
                    if (read_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < K; i++)
            begin
                dist_reg[i] <= DIST_MAX;
                id_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            for (int i = 0; i < K; i++)
            begin
                dist_reg[i] <= dist_next[i];
                id_reg[i]   <= id_next[i];
            end
            if (load_read)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_READ && res_push)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Hold the current offer and the read snapshot
    always_ff @(posedge clk)
    begin
        if (load_offer)
        begin
            gt_reg       <= gt_row;
            dup_reg      <= dup_row;
            cur_self_reg <= cmd_rd.self_hit;
            cur_id_reg   <= cmd_rd.id;
            cur_dist_reg <= cmd_rd.sq_dist;
        end
        if (load_read)
        begin
            worst_reg <= dist_reg[K-1];
        end
    end

`ifndef SYNTH
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_read_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && res_push && !read_last) |=> (state_reg == S_READ))
        else $error("read-out stream ended early");

    a_worst_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS && res_push && ins_ok)
        |=> (dist_reg[K-1] <= $past(dist_reg[K-1])))
        else $error("insert raised the K-th distance");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd_rd.func == FUNC_CLEAR) |=> (valid_reg == '0))
        else $error("clear left valid entries");
`endif

endmodule

// ===== src/k_nearest_neighbor_list.sv =====
// Channel  | Direction | Handshake               | Carries
// -------- | --------- | ----------------------- | -----------------------------------------
// item     | in        | push / full             | func, cand_x, cand_y, cand_z, cand_id
// result   | out       | empty / pop             | inserted, worst_dist, entry_* , last
// config   | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// An item passes a 4-stage distance pipeline, then waits in a 2-entry command queue.
// The list unit handles an offer by latching the compare row, then doing the shift insert,
// a clear or unused code directly from idle, and a read by taking the item, then giving one
// rank per cycle while the result queue has room, by rotating the list.
// The list lives in flip-flops and reset clears it at once; no sweep follows reset.
// A full result queue stalls the list unit, a full command queue stalls the pipeline.
module k_nearest_neighbor_list import knn_pkg::*; #(
    parameter int K          = K_DEFAULT,
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // item channel
    input  logic                         push,
    output logic                         full,
    input  logic [FUNC_BITS-1:0]         func,
    input  logic signed [QUERY_BITS-1:0] cand_x,
    input  logic signed [QUERY_BITS-1:0] cand_y,
    input  logic signed [QUERY_BITS-1:0] cand_z,
    input  logic [ID_BITS-1:0]           cand_id,
    // result channel
    output logic                         empty,
    input  logic                         pop,
    output logic                         inserted,
    output logic [DIST_BITS-1:0]         worst_dist,
    output logic [INDEX_BITS-1:0]        entry_index,
    output logic [ID_BITS-1:0]           entry_id,
    output logic [DIST_BITS-1:0]         entry_dist,
    output logic                         entry_valid,
    output logic                         last,
    // configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

    logic    cmdq_push, cmdq_full, cmdq_empty, cmdq_pop;
    cmd_t    cmdq_wr, cmdq_rd;
    logic    resq_push, resq_full, resq_empty;
    result_t resq_wr, resq_rd;

    assign cfg_ready = 1'b1;

    knn_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .cand_x    (cand_x),
        .cand_y    (cand_y),
        .cand_z    (cand_z),
        .cand_id   (cand_id),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmdq_push),
        .cmd_data  (cmdq_wr),
        .cmd_full  (cmdq_full)
    );

    knn_fifo #(
        .WIDTH      ($bits(cmd_t)),
        .DEPTH_LOG2 (CMDQ_DEPTH_LOG2)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmdq_push),
        .wr_data (cmdq_wr),
        .rd_en   (cmdq_pop),
        .rd_data (cmdq_rd),
        .full    (cmdq_full),
        .empty   (cmdq_empty)
    );

    knn_list #(
        .K (K)
    ) u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_rd    (cmdq_rd),
        .cmd_empty (cmdq_empty),
        .cmd_pop   (cmdq_pop),
        .res_push  (resq_push),
        .res_data  (resq_wr),
        .res_full  (resq_full)
    );

    knn_fifo #(
        .WIDTH      ($bits(result_t)),
        .DEPTH_LOG2 (RESQ_DEPTH_LOG2)
    ) u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (resq_push),
        .wr_data (resq_wr),
        .rd_en   (pop && !resq_empty),
        .rd_data (resq_rd),
        .full    (resq_full),
        .empty   (resq_empty)
    );

    // Unpack the oldest result onto the ports
    assign empty       = resq_empty;
    assign inserted    = resq_rd.inserted;
    assign worst_dist  = resq_rd.worst_dist;
    assign entry_index = resq_rd.entry_index;
    assign entry_id    = resq_rd.entry_id;
    assign entry_dist  = resq_rd.entry_dist;
    assign entry_valid = resq_rd.entry_valid;
    assign last        = resq_rd.last;

endmodule
